FILE: hw/rtl/pva_pkg.sv
`timescale 1ns / 1ps

package pva_pkg;

  // voice pool size and derived widths
  localparam int VOICES  = 8;
  localparam int VOICE_W = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CNT_W   = $clog2(VOICES + 1);

  // fixed field widths
  localparam int NOTE_W     = 16;
  localparam int OUT_VOICE_W = 3;
  localparam int CFG_W      = 4;
  localparam int RESET_COUNT = 8;

  localparam logic signed [NOTE_W-1:0] INVALID_PITCH = 16'sh8000;

  // note event codes
  localparam logic OP_NOTE_ON  = 1'b0;
  localparam logic OP_NOTE_OFF = 1'b1;

  typedef logic [VOICE_W-1:0] voice_idx_t;
  typedef logic [CNT_W-1:0]   voice_cnt_t;

  // input beat
  typedef struct packed {
    logic                     op;
    logic signed [NOTE_W-1:0] note;
  } in_item_t;

  // result beat
  typedef struct packed {
    logic [OUT_VOICE_W-1:0] voice;
    logic                   ok;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic assign_voice;
    logic scan_next;
    logic release_voice;
    logic miss;
    logic emit;
  } pva_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       pitch_bad;
    logic       op_off;
    logic       busy_empty;
    logic       hit;
    logic       scan_last;
    logic       out_free;
    voice_cnt_t busy_total;
    voice_cnt_t free_total;
  } pva_status_t;

  // saturate a voice count write into 1..VOICES
  function automatic voice_cnt_t clamp_count(input logic [CFG_W-1:0] v);
    voice_cnt_t res;
    if (v == '0) begin
      res = CNT_W'(1);
    end else if (32'(v) > VOICES) begin
      res = CNT_W'(VOICES);
    end else begin
      res = CNT_W'(v);
    end
    return res;
  endfunction

endpackage

FILE: hw/rtl/pva_datapath.sv
`timescale 1ns / 1ps

module pva_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pva_pkg::in_item_t               in_data,
  input  logic                            cfg_we,
  input  logic [pva_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            out_stall,
  input  pva_pkg::pva_cmd_t               cmd,
  output pva_pkg::pva_status_t            status,
  output logic                            out_valid,
  output pva_pkg::out_item_t              out_data
);

  // voice state
  logic signed [pva_pkg::NOTE_W-1:0] pitch_r   [pva_pkg::VOICES];
  logic signed [pva_pkg::NOTE_W-1:0] pitch_nxt [pva_pkg::VOICES];
  pva_pkg::voice_idx_t busy_r   [pva_pkg::VOICES];
  pva_pkg::voice_idx_t busy_nxt [pva_pkg::VOICES];
  pva_pkg::voice_idx_t free_r   [pva_pkg::VOICES];
  pva_pkg::voice_idx_t free_nxt [pva_pkg::VOICES];
  pva_pkg::voice_cnt_t busy_total_r, busy_total_nxt;
  pva_pkg::voice_cnt_t free_total_r, free_total_nxt;

  // working item, walk position and result
  pva_pkg::in_item_t   item_r, item_nxt;
  pva_pkg::voice_idx_t scan_idx_r, scan_idx_nxt;
  logic [pva_pkg::OUT_VOICE_W-1:0] res_voice_r, res_voice_nxt;
  logic                res_ok_r, res_ok_nxt;
  pva_pkg::out_item_t  out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;

  pva_pkg::voice_idx_t voice_on;
  pva_pkg::voice_idx_t scan_voice;
  pva_pkg::voice_cnt_t init_count;

  assign voice_on   = (free_total_r != '0) ? free_r[0] : busy_r[0];
  assign scan_voice = busy_r[scan_idx_r];
  assign init_count = pva_pkg::clamp_count(cfg_data);

  // status toward the controller
  always_comb begin
    status.pitch_bad  = (item_r.note == pva_pkg::INVALID_PITCH);
    status.op_off     = (item_r.op == pva_pkg::OP_NOTE_OFF);
    status.busy_empty = (busy_total_r == '0);
    status.hit        = (pitch_r[scan_voice] == item_r.note);
    status.scan_last  = ((pva_pkg::CNT_W'(scan_idx_r) + pva_pkg::CNT_W'(1)) == busy_total_r);
    status.out_free   = !out_valid_r || !out_stall;
    status.busy_total = busy_total_r;
    status.free_total = free_total_r;
  end

  // next state of lists, pitches and result
  always_comb begin
    pitch_nxt      = pitch_r;
    busy_nxt       = busy_r;
    free_nxt       = free_r;
    busy_total_nxt = busy_total_r;
    free_total_nxt = free_total_r;
    item_nxt       = item_r;
    scan_idx_nxt   = scan_idx_r;
    res_voice_nxt  = res_voice_r;
    res_ok_nxt     = res_ok_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;

    if (cmd.latch) begin
      item_nxt     = in_data;
      scan_idx_nxt = '0;
    end

    if (cmd.scan_next) begin
      scan_idx_nxt = scan_idx_r + pva_pkg::VOICE_W'(1);
    end

    if (cmd.miss) begin
      res_voice_nxt = '0;
      res_ok_nxt    = 1'b0;
    end

    // note on: oldest free voice, else steal the oldest busy one
    if (cmd.assign_voice) begin
      res_voice_nxt       = pva_pkg::OUT_VOICE_W'(voice_on);
      res_ok_nxt          = 1'b1;
      pitch_nxt[voice_on] = item_r.note;
      if (free_total_r != '0) begin
        for (int j = 0; j < pva_pkg::VOICES - 1; j++) begin
          free_nxt[j] = free_r[j+1];
        end
        free_total_nxt = free_total_r - pva_pkg::CNT_W'(1);
        busy_nxt[busy_total_r[pva_pkg::VOICE_W-1:0]] = voice_on;
        busy_total_nxt = busy_total_r + pva_pkg::CNT_W'(1);
      end else begin
        for (int j = 0; j < pva_pkg::VOICES - 1; j++) begin
          if (pva_pkg::CNT_W'(j + 1) < busy_total_r) begin
            busy_nxt[j] = busy_r[j+1];
          end
        end
        for (int j = 0; j < pva_pkg::VOICES; j++) begin
          if (pva_pkg::CNT_W'(j + 1) == busy_total_r) begin
            busy_nxt[j] = voice_on;
          end
        end
      end
    end

    // note off: drop matched entry from the busy list, append to free queue
    if (cmd.release_voice) begin
      res_voice_nxt         = pva_pkg::OUT_VOICE_W'(scan_voice);
      res_ok_nxt            = 1'b1;
      pitch_nxt[scan_voice] = pva_pkg::INVALID_PITCH;
      for (int j = 0; j < pva_pkg::VOICES - 1; j++) begin
        if ((pva_pkg::VOICE_W'(j) >= scan_idx_r) &&
            (pva_pkg::CNT_W'(j + 1) < busy_total_r)) begin
          busy_nxt[j] = busy_r[j+1];
        end
      end
      busy_total_nxt = busy_total_r - pva_pkg::CNT_W'(1);
      free_nxt[free_total_r[pva_pkg::VOICE_W-1:0]] = scan_voice;
      free_total_nxt = free_total_r + pva_pkg::CNT_W'(1);
    end

    // output register
    if (cmd.emit) begin
      out_nxt.voice = res_voice_r;
      out_nxt.ok    = res_ok_r;
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    // voice count write restarts all lists
    if (cfg_we) begin
      busy_total_nxt = '0;
      free_total_nxt = init_count;
      for (int j = 0; j < pva_pkg::VOICES; j++) begin
        pitch_nxt[j] = pva_pkg::INVALID_PITCH;
        free_nxt[j]  = pva_pkg::VOICE_W'(j);
      end
    end
  end

  // state with reset values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_total_r <= '0;
      free_total_r <= pva_pkg::clamp_count(pva_pkg::CFG_W'(pva_pkg::RESET_COUNT));
      out_valid_r  <= 1'b0;
      for (int j = 0; j < pva_pkg::VOICES; j++) begin
        pitch_r[j] <= pva_pkg::INVALID_PITCH;
        free_r[j]  <= pva_pkg::VOICE_W'(j);
      end
    end else begin
      busy_total_r <= busy_total_nxt;
      free_total_r <= free_total_nxt;
      out_valid_r  <= out_valid_nxt;
      pitch_r      <= pitch_nxt;
      free_r       <= free_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    busy_r      <= busy_nxt;
    item_r      <= item_nxt;
    scan_idx_r  <= scan_idx_nxt;
    res_voice_r <= res_voice_nxt;
    res_ok_r    <= res_ok_nxt;
    out_r       <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: hw/rtl/pva_ctrl.sv
`timescale 1ns / 1ps

module pva_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  pva_pkg::pva_status_t status,
  output pva_pkg::pva_cmd_t    cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (status.pitch_bad) begin
          cmd.miss  = 1'b1;
          state_nxt = S_EMIT;
        end else if (!status.op_off) begin
          cmd.assign_voice = 1'b1;
          state_nxt        = S_EMIT;
        end else if (status.busy_empty) begin
          cmd.miss  = 1'b1;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (status.hit) begin
          cmd.release_voice = 1'b1;
          state_nxt         = S_EMIT;
        end else if (status.scan_last) begin
          cmd.miss  = 1'b1;
          state_nxt = S_EMIT;
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: hw/rtl/poly_voice_allocator.sv
`timescale 1ns / 1ps

// Polyphonic voice allocator. A note-on (op 0) gets the oldest free voice,
// or steals the oldest busy voice when none is free; a note-off (op 1) frees
// the oldest busy voice holding that pitch. Pitch 0x8000 is rejected with
// ok 0, as is a note-off that matches nothing; voice reads 0 whenever ok is
// 0. One item is handled at a time: a note-on, an invalid pitch or a note-off
// with no busy voice goes from accept through the execute and emit states,
// and the input reopens once the result is registered. A note-off that walks
// the busy list passes through a scan state that compares one entry per cycle
// against the pitch store, stopping at the first match or at the end of the
// busy list. The result sits in an output register, so the next item is taken
// while a stalled result waits; the result after it is held in the result
// registers while the sequencer waits until the first one leaves. Writing
// cfg_voice_count (saturated to 1..8) restarts all lists at once.
module poly_voice_allocator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  pva_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output pva_pkg::out_item_t              out_data,
  input  logic                            cfg_we,
  input  logic [pva_pkg::CFG_W-1:0]       cfg_voice_count
);

  pva_pkg::pva_cmd_t    cmd;
  pva_pkg::pva_status_t status;

  // sequencer
  pva_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // voice lists and result register
  pva_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_voice_count),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  // busy and free totals together never exceed the voice pool
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(status.busy_total) + 32'(status.free_total)) <= pva_pkg::VOICES)
    else $error("busy and free totals exceed voice pool");

  // an accepted beat closes the input until its result is built
  a_accept_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input open right after accept");

  // failed results carry voice zero
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.ok) |-> (out_data.voice == '0))
    else $error("failed result with nonzero voice");
`endif

endmodule

FILE: sim/pva_checker.sv
`timescale 1ns / 1ps

module pva_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  pva_pkg::in_item_t         in_data,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  pva_pkg::out_item_t        out_data,
  input  logic                      cfg_we,
  input  logic [pva_pkg::CFG_W-1:0] cfg_voice_count,
  output int                        pending,
  output int                        errors
);

  // model of the voice pool
  logic signed [pva_pkg::NOTE_W-1:0] pitch_of [pva_pkg::VOICES];
  pva_pkg::voice_idx_t               busy_q [$];
  pva_pkg::voice_idx_t               free_q [$];

  pva_pkg::out_item_t expected_beats [$];
  int                 fail_count = 0;
  pva_pkg::out_item_t want;

  // clear pitches and lists for a new voice count
  function automatic void restart_pool(input logic [pva_pkg::CFG_W-1:0] raw);
    int n;
    if (raw == '0) begin
      n = 1;
    end else if (int'(raw) > pva_pkg::VOICES) begin
      n = pva_pkg::VOICES;
    end else begin
      n = int'(raw);
    end
    busy_q.delete();
    free_q.delete();
    for (int i = 0; i < pva_pkg::VOICES; i++) begin
      pitch_of[i] = pva_pkg::INVALID_PITCH;
      if (i < n) free_q.push_back(pva_pkg::voice_idx_t'(i));
    end
  endfunction

  // apply one note event and return the result beat it should produce
  function automatic pva_pkg::out_item_t predict_beat(input pva_pkg::in_item_t beat);
    pva_pkg::out_item_t  res;
    pva_pkg::voice_idx_t v;
    int                  slot;
    res = '0;
    slot = -1;
    if (beat.note == pva_pkg::INVALID_PITCH) return res;
    if (beat.op == pva_pkg::OP_NOTE_ON) begin
      // oldest free voice, else steal the oldest busy one
      if (free_q.size() != 0) begin
        v = free_q.pop_front();
      end else begin
        v = busy_q.pop_front();
      end
      busy_q.push_back(v);
      pitch_of[v] = beat.note;
      res.voice = pva_pkg::OUT_VOICE_W'(v);
      res.ok = 1'b1;
    end else begin
      // first busy voice in age order holding this pitch
      foreach (busy_q[i]) begin
        if (slot < 0 && pitch_of[busy_q[i]] == beat.note) slot = i;
      end
      if (slot >= 0) begin
        v = busy_q[slot];
        busy_q.delete(slot);
        pitch_of[v] = pva_pkg::INVALID_PITCH;
        free_q.push_back(v);
        res.voice = pva_pkg::OUT_VOICE_W'(v);
        res.ok = 1'b1;
      end
    end
    return res;
  endfunction

  // watch config, input and result beats
  always @(posedge clk) begin
    if (!rst_n) begin
      restart_pool(pva_pkg::CFG_W'(pva_pkg::RESET_COUNT));
      expected_beats.delete();
    end else begin
      if (cfg_we) restart_pool(cfg_voice_count);
      if (in_valid && !in_stall) expected_beats.push_back(predict_beat(in_data));
      if (out_valid && !out_stall) begin
        if (expected_beats.size() == 0) begin
          $display("%0t: result beat with nothing expected: voice %0d ok %0b",
                   $time, out_data.voice, out_data.ok);
          fail_count++;
        end else begin
          want = expected_beats.pop_front();
          if (out_data.voice !== want.voice) begin
            $display("%0t: voice mismatch: expected %0d, actual %0d",
                     $time, want.voice, out_data.voice);
            fail_count++;
          end
          if (out_data.ok !== want.ok) begin
            $display("%0t: ok mismatch: expected %0b, actual %0b",
                     $time, want.ok, out_data.ok);
            fail_count++;
          end
        end
      end
    end
    pending <= expected_beats.size();
    errors  <= fail_count;
  end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int PHASES          = 9;
  localparam int ITEMS_PER_PHASE = 180;
  localparam int SETTLE_CYCLES   = 24;
  localparam int HOLD_CYCLES     = 100;
  localparam int CYCLE_LIMIT     = 500000;

  localparam logic [pva_pkg::CFG_W-1:0] PHASE_COUNT [PHASES] =
    '{4'd8, 4'd0, 4'd15, 4'd1, 4'd8, 4'd3, 4'd2, 4'd0, 4'd0};

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  pva_pkg::in_item_t           in_data = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  pva_pkg::out_item_t          out_data;
  logic                        cfg_we = 1'b0;
  logic [pva_pkg::CFG_W-1:0]   cfg_voice_count = '0;

  logic idle_on = 1'b1;
  logic squeeze = 1'b0;
  logic hold_used = 1'b0;
  int   hold_left = 0;
  int   pending;
  int   errors;
  int   cycle_count = 0;

  poly_voice_allocator uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .cfg_we          (cfg_we),
    .cfg_voice_count (cfg_voice_count)
  );

  pva_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .cfg_we          (cfg_we),
    .cfg_voice_count (cfg_voice_count),
    .pending         (pending),
    .errors          (errors)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off when asked
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (squeeze && !hold_used) begin
      hold_used <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= idle_on && ($urandom_range(0, 99) < 21);
    end
  end

  // offer one beat after a random gap, return at the accepting edge
  task automatic send_item(input logic kind,
                           input logic signed [pva_pkg::NOTE_W-1:0] pitch);
    while (idle_on && $urandom_range(0, 99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{op: kind, note: pitch};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // mostly notes from a small pitch set so note-offs find matches
  task automatic send_random(input logic signed [pva_pkg::NOTE_W-1:0] base);
    int                                r;
    logic                              kind;
    logic signed [pva_pkg::NOTE_W-1:0] pitch;
    r = $urandom_range(0, 99);
    kind = ($urandom_range(0, 99) < 55) ? pva_pkg::OP_NOTE_ON : pva_pkg::OP_NOTE_OFF;
    if (r < 3) begin
      pitch = pva_pkg::INVALID_PITCH;
    end else if (r < 15) begin
      pitch = pva_pkg::NOTE_W'($urandom);
    end else begin
      pitch = base + pva_pkg::NOTE_W'($urandom_range(0, 11));
    end
    send_item(kind, pitch);
  endtask

  // wait for all expected results to drain, then write the voice count
  task automatic load_voice_count(input logic [pva_pkg::CFG_W-1:0] cnt);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we          <= 1'b1;
    cfg_voice_count <= cnt;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // edge pitches, stealing, repeated pitches and misses with all eight voices
  task automatic run_directed();
    send_item(pva_pkg::OP_NOTE_ON,  pva_pkg::INVALID_PITCH);
    send_item(pva_pkg::OP_NOTE_OFF, pva_pkg::INVALID_PITCH);
    send_item(pva_pkg::OP_NOTE_OFF, 16'sd60);
    send_item(pva_pkg::OP_NOTE_ON,  16'sh7fff);
    send_item(pva_pkg::OP_NOTE_ON,  16'sh0000);
    send_item(pva_pkg::OP_NOTE_ON,  -16'sd1);
    send_item(pva_pkg::OP_NOTE_ON,  16'sh8001);
    send_item(pva_pkg::OP_NOTE_ON,  16'sd60);
    send_item(pva_pkg::OP_NOTE_ON,  16'sd60);
    send_item(pva_pkg::OP_NOTE_ON,  16'sd61);
    send_item(pva_pkg::OP_NOTE_ON,  16'sd62);
    // pool full: these two steal the oldest voices
    send_item(pva_pkg::OP_NOTE_ON,  16'sd63);
    send_item(pva_pkg::OP_NOTE_ON,  16'sd64);
    send_item(pva_pkg::OP_NOTE_OFF, 16'sh7fff);
    send_item(pva_pkg::OP_NOTE_OFF, 16'sd60);
    send_item(pva_pkg::OP_NOTE_OFF, 16'sd60);
    send_item(pva_pkg::OP_NOTE_OFF, 16'sd60);
    send_item(pva_pkg::OP_NOTE_OFF, 16'sh8001);
    send_item(pva_pkg::OP_NOTE_ON,  16'sd65);
    send_item(pva_pkg::OP_NOTE_OFF, 16'sd64);
    send_item(pva_pkg::OP_NOTE_OFF, -16'sd1);
  endtask

  // reset, then phases at several voice counts
  initial begin
    logic signed [pva_pkg::NOTE_W-1:0] base;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) begin
        run_directed();
      end else if (ph < 7) begin
        load_voice_count(PHASE_COUNT[ph]);
      end else begin
        load_voice_count(pva_pkg::CFG_W'($urandom_range(0, 15)));
      end
      // one phase runs with no idling on either side
      idle_on <= (ph != 4);
      if (ph == 2) squeeze <= 1'b1;
      base = pva_pkg::NOTE_W'($urandom);
      repeat (ITEMS_PER_PHASE) send_random(base);
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/pva_pkg.sv
hw/rtl/pva_datapath.sv
hw/rtl/pva_ctrl.sv
hw/rtl/poly_voice_allocator.sv
sim/pva_checker.sv
sim/testbench.sv
